FILE: src/joint_damp_then_hold_stop_macros.svh
// ----------------------------------------------------------------------------
// joint_damp_then_hold_stop assertion macros
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef JOINT_DAMP_THEN_HOLD_STOP_MACROS_SVH
`define JOINT_DAMP_THEN_HOLD_STOP_MACROS_SVH

`ifndef SYNTHESIS

`define JDTHS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("jdths check failed");

`define JDTHS_ASSERT_NEXT(lbl, cause, effect) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error("jdths sequence check failed");

`else

`define JDTHS_ASSERT(lbl, prop)

`define JDTHS_ASSERT_NEXT(lbl, cause, effect)

`endif

`endif

FILE: src/jdths_pkg.sv
// ----------------------------------------------------------------------------
// jdths_pkg
// Shared types and constants of the joint damping / hold stop controller.
// ----------------------------------------------------------------------------
`default_nettype none

package jdths_pkg;

	localparam int JOINTS_DEFAULT = 7;
	localparam int GAIN_W         = 31;
	localparam int WORD_W         = 32;
	localparam int FRAC_BITS      = 16;
	localparam int CFG_IDX_W      = 2;

	localparam logic [GAIN_W-1:0] SPEED_LIMIT_RESET = 31'd3277;

	typedef enum logic [1:0] {
		MODE_TICK = 2'd0,
		MODE_STOP = 2'd1,
		MODE_FREE = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STIFFNESS = 2'd0,
		CFG_DAMPING   = 2'd1,
		CFG_SPEED_LIM = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] stiffness;
		logic [GAIN_W-1:0] damping;
		logic [GAIN_W-1:0] speed_limit;
	} cfg_t;

endpackage

`default_nettype wire

FILE: src/joint_damp_then_hold_stop.sv
// ----------------------------------------------------------------------------
// joint_damp_then_hold_stop
// Per-joint stop controller: damping until slow, then PD hold on latched position.
// ----------------------------------------------------------------------------
// pipeline: an accepted item waits in the input register and loads the result
//   register once the output is not stalled
// throughput: one item per cycle while the output is not stalled; joint state is
//   updated as the item leaves the input register, so the following item already sees it
// reset: stop active, all stopped flags clear, gains zero, speed limit 3277;
//   hold targets are not reset and are read only once their joint has latched
`default_nettype none

module joint_damp_then_hold_stop
	import jdths_pkg::*;
#(
	parameter int JOINTS = JOINTS_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [1:0]             mode,
	input  wire logic [2:0]             joint_index,
	input  wire logic signed [WORD_W-1:0] position,
	input  wire logic signed [WORD_W-1:0] velocity,

	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic signed [WORD_W-1:0]    torque_command,
	output logic                        joint_stopped,
	output logic                        all_at_rest,
	output logic                        stop_active,
	output logic                        trigger_accepted,

	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [GAIN_W-1:0]      cfg_data
);

`include "joint_damp_then_hold_stop_macros.svh"

	localparam int SEL_W = 5;

	cfg_t cfg;

	assign cfg_ready = 1'b1;

	jdths_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// input register
	logic                      valid_s1;
	mode_t                     mode_s1;
	logic [2:0]                idx_s1;
	logic signed [WORD_W-1:0]  pos_s1;
	logic signed [WORD_W-1:0]  vel_s1;

	// joint state
	logic                      stop_q;
	logic [JOINTS-1:0]         flags_q;
	logic signed [WORD_W-1:0]  target_q [JOINTS];

	// result register
	logic                      valid_s2;
	logic signed [WORD_W-1:0]  torque_s2;
	logic                      jstop_s2;
	logic                      rest_s2;
	logic                      stop_s2;
	logic                      accepted_s2;

	logic advance;
	logic in_fire;
	logic s1_fire;

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_fire  = in_valid && !in_stall;
	assign s1_fire  = valid_s1 && advance;

	// step logic
	logic [JOINTS-1:0]         hit;
	logic                      in_range;
	logic                      flag_sel;
	logic signed [WORD_W-1:0]  target_sel;
	logic                      tick_live;
	logic [WORD_W-1:0]         speed;
	logic                      slow;
	logic                      latch;
	logic                      flag_eff;
	logic signed [WORD_W-1:0]  target_eff;
	logic signed [WORD_W:0]    pos_err;
	logic [GAIN_W-1:0]         k_eff;
	logic signed [WORD_W-1:0]  pd_out;
	logic                      stop_nxt;
	logic [JOINTS-1:0]         flags_nxt;
	logic                      accepted;
	logic                      jstop;

	always_comb begin
		in_range   = 1'b0;
		flag_sel   = 1'b0;
		target_sel = '0;
		for (int i = 0; i < JOINTS; i++) begin
			hit[i]     = (SEL_W'(i) == {2'b00, idx_s1});
			in_range   = in_range | hit[i];
			flag_sel   = flag_sel | (hit[i] & flags_q[i]);
			// a target is read only for a joint whose stopped flag is set
			target_sel = target_sel | ((hit[i] && flags_q[i]) ? target_q[i] : '0);
		end

		tick_live  = (mode_s1 == MODE_TICK) && in_range && stop_q;
		speed      = vel_s1[WORD_W-1] ? WORD_W'(-vel_s1) : WORD_W'(vel_s1);
		slow       = speed < {1'b0, cfg.speed_limit};
		latch      = tick_live && !flag_sel && slow;
		flag_eff   = flag_sel || latch;
		target_eff = latch ? pos_s1 : target_sel;
		pos_err    = {target_eff[WORD_W-1], target_eff} - {pos_s1[WORD_W-1], pos_s1};
		k_eff      = flag_eff ? cfg.stiffness : '0;

		stop_nxt  = stop_q;
		flags_nxt = flags_q;
		accepted  = 1'b0;
		unique case (mode_s1)
			MODE_TICK: begin
				if (latch)
					flags_nxt = flags_q | hit;
			end
			MODE_STOP: begin
				if (!stop_q) begin
					stop_nxt  = 1'b1;
					flags_nxt = '0;
					accepted  = 1'b1;
				end
			end
			MODE_FREE: begin
				stop_nxt = 1'b0;
				accepted = 1'b1;
			end
			default: ; // unused mode, no effect
		endcase

		jstop = |(flags_nxt & hit);
	end

	jdths_torque u_torque (
		.stiffness (k_eff),
		.pos_err   (pos_err),
		.damping   (cfg.damping),
		.velocity  (vel_s1),
		.torque    (pd_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			stop_q   <= 1'b1;
			flags_q  <= '0;
		end else begin
			if (in_fire)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= valid_s1;
			if (s1_fire) begin
				stop_q  <= stop_nxt;
				flags_q <= flags_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_s1 <= mode_t'(mode);
			idx_s1  <= joint_index;
			pos_s1  <= position;
			vel_s1  <= velocity;
		end
		if (s1_fire) begin
			for (int i = 0; i < JOINTS; i++) begin
				if (latch && hit[i])
					target_q[i] <= pos_s1;
			end
			torque_s2   <= tick_live ? pd_out : '0;
			jstop_s2    <= jstop;
			rest_s2     <= &flags_nxt;
			stop_s2     <= stop_nxt;
			accepted_s2 <= accepted;
		end
	end

	assign out_valid        = valid_s2;
	assign torque_command   = torque_s2;
	assign joint_stopped    = jstop_s2;
	assign all_at_rest      = rest_s2;
	assign stop_active      = stop_s2;
	assign trigger_accepted = accepted_s2;

	`JDTHS_ASSERT_NEXT(a_stop_clears, s1_fire && mode_s1 == MODE_STOP && !stop_q, stop_q && flags_q == '0)
	`JDTHS_ASSERT_NEXT(a_free_ends, s1_fire && mode_s1 == MODE_FREE, !stop_q)
	`JDTHS_ASSERT_NEXT(a_state_holds, !s1_fire, $stable(flags_q) && $stable(stop_q))
	`JDTHS_ASSERT(a_torque_only_in_stop, valid_s2 && torque_s2 != '0 |-> stop_s2)
	`JDTHS_ASSERT(a_trigger_not_tick, valid_s1 && mode_s1 == MODE_TICK |-> !accepted)

endmodule

`default_nettype wire

FILE: src/jdths_cfg.sv
// ----------------------------------------------------------------------------
// jdths_cfg
// Gain and speed limit registers, written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module jdths_cfg
	import jdths_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [GAIN_W-1:0]    wr_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stiffness   <= '0;
			cfg_q.damping     <= '0;
			cfg_q.speed_limit <= SPEED_LIMIT_RESET;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_STIFFNESS: cfg_q.stiffness   <= wr_data;
				CFG_DAMPING:   cfg_q.damping     <= wr_data;
				CFG_SPEED_LIM: cfg_q.speed_limit <= wr_data;
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: src/jdths_torque.sv
// ----------------------------------------------------------------------------
// jdths_torque
// PD torque: floor((stiffness*err - damping*vel) / 2^16), saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module jdths_torque
	import jdths_pkg::*;
(
	input  wire logic        [GAIN_W-1:0] stiffness,
	input  wire logic signed [WORD_W:0]   pos_err,
	input  wire logic        [GAIN_W-1:0] damping,
	input  wire logic signed [WORD_W-1:0] velocity,
	output logic signed      [WORD_W-1:0] torque
);

	localparam int PROD_W = 2 * WORD_W + 2;
	localparam int SHR_W  = PROD_W - FRAC_BITS;

	logic signed [WORD_W-1:0] k_s;
	logic signed [WORD_W-1:0] g_s;
	logic signed [PROD_W-1:0] p_stiff;
	logic signed [PROD_W-1:0] p_damp;
	logic signed [PROD_W-1:0] sum;
	logic signed [SHR_W-1:0]  scaled;
	logic                     fits;

	always_comb begin
		k_s     = $signed({1'b0, stiffness});
		g_s     = $signed({1'b0, damping});
		p_stiff = PROD_W'(k_s) * PROD_W'(pos_err);
		p_damp  = PROD_W'(g_s) * PROD_W'(velocity);
		sum     = p_stiff - p_damp;
		// arithmetic shift gives the floor of the division
		scaled  = SHR_W'(sum >>> FRAC_BITS);
		fits    = (scaled[SHR_W-1:WORD_W-1] == '0) || (scaled[SHR_W-1:WORD_W-1] == '1);
		if (fits)
			torque = scaled[WORD_W-1:0];
		else if (scaled[SHR_W-1])
			torque = {1'b1, {(WORD_W-1){1'b0}}};
		else
			torque = {1'b0, {(WORD_W-1){1'b1}}};
	end

endmodule

`default_nettype wire
